@@ rtl/rcnd_pkg.sv @@
// shared types, register codes and constants of the roi crop and nearest downscaler
package rcnd_pkg;

  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int TGT_W       = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int DIV_CNT_W   = $clog2(DIM_W + 1);

  localparam logic [16:0] MAX_DIMENSION = 17'd4096;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_LEFT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_TOP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_WIDTH  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_HEIGHT = 3'd7;

  typedef struct packed {
    logic [7:0] gray_in;
    logic       frame_begin;
  } in_t;

  typedef struct packed {
    logic [7:0]       gray_out;
    logic [POS_W-1:0] out_column;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic [POS_W-1:0] region_left;
    logic [POS_W-1:0] region_top;
    logic [DIM_W-1:0] region_width;
    logic [DIM_W-1:0] region_height;
    logic [DIM_W-1:0] output_width;
    logic [DIM_W-1:0] output_height;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] col_quo;
    logic [DIM_W-1:0] col_rem;
    logic [DIM_W-1:0] row_quo;
    logic [DIM_W-1:0] row_rem;
  } step_t;

  typedef struct packed {
    logic [7:0]       gray;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } q_entry_t;

endpackage

@@ rtl/rcnd_div.sv @@
// restoring divider, one quotient bit per cycle
module rcnd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rcnd_pkg::DIM_W-1:0] dividend,
  input  logic [rcnd_pkg::DIM_W-1:0] divisor,
  output logic                      busy,
  output logic [rcnd_pkg::DIM_W-1:0] quotient,
  output logic [rcnd_pkg::DIM_W-1:0] remainder
);

  logic [rcnd_pkg::DIM_W-1:0]     rem_acc;
  logic [rcnd_pkg::DIM_W-1:0]     quo;
  logic [rcnd_pkg::DIV_CNT_W-1:0] count;
  logic [rcnd_pkg::DIM_W:0]       trial;
  logic                           fits;

  assign trial = {rem_acc, quo[rcnd_pkg::DIM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= rcnd_pkg::DIV_CNT_W'(rcnd_pkg::DIM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == rcnd_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_acc <= '0;
      quo     <= dividend;
    end else if (busy) begin
      rem_acc <= fits ? rcnd_pkg::DIM_W'(trial - {1'b0, divisor})
                      : trial[rcnd_pkg::DIM_W-1:0];
      quo     <= {quo[rcnd_pkg::DIM_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem_acc;

endmodule

@@ rtl/rcnd_front.sv @@
// front end: source counters, target stepping and pixel selection
module rcnd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcnd_pkg::in_t      in_data,
  input  rcnd_pkg::cfg_t     cfg,
  input  rcnd_pkg::step_t    step,
  input  logic               cfg_ok,
  input  logic               hold,
  input  logic               q_ready,
  output logic               push,
  output rcnd_pkg::q_entry_t push_entry
);

  localparam int DW = rcnd_pkg::DIM_W;
  localparam int TW = rcnd_pkg::TGT_W;

  logic [DW-1:0] src_col, src_row, next_col, next_row, col_rem, row_rem;
  logic [TW-1:0] tgt_col, tgt_row;
  logic          frame_ok;

  logic [DW-1:0] e_src_col, e_src_row, e_next_col, e_next_row, e_col_rem, e_row_rem;
  logic [TW-1:0] e_tgt_col, e_tgt_row;
  logic          e_frame_ok;

  logic [DW-1:0] src_col_next, src_row_next, next_col_next, next_row_next;
  logic [DW-1:0] col_rem_next, row_rem_next;
  logic [TW-1:0] tgt_col_next, tgt_row_next;

  logic          accept, begin_f, active, row_hit, emit, row_end, row_adv;
  logic [DW:0]   col_sum, row_sum;
  logic          col_carry, row_carry;
  logic [DW-1:0] col_rem_step, row_rem_step;
  logic [TW-1:0] tgt_col_step, tgt_row_step;

  assign in_ready = q_ready && !hold;
  assign accept   = in_valid && in_ready;
  assign begin_f  = in_data.frame_begin;

  // frame start restarts all counters before the pixel is judged
  always_comb begin
    e_src_col  = begin_f ? '0 : src_col;
    e_src_row  = begin_f ? '0 : src_row;
    e_next_col = begin_f ? '0 : next_col;
    e_next_row = begin_f ? '0 : next_row;
    e_col_rem  = begin_f ? '0 : col_rem;
    e_row_rem  = begin_f ? '0 : row_rem;
    e_tgt_col  = begin_f ? {2'b00, cfg.region_left} : tgt_col;
    e_tgt_row  = begin_f ? {2'b00, cfg.region_top} : tgt_row;
    e_frame_ok = begin_f ? cfg_ok : frame_ok;
  end

  assign active  = e_frame_ok && cfg_ok;
  assign row_hit = {1'b0, e_src_row} == e_tgt_row;
  assign emit    = active && (e_next_row < cfg.output_height) &&
                   (e_next_col < cfg.output_width) && row_hit &&
                   ({1'b0, e_src_col} == e_tgt_col);
  assign row_end = ({1'b0, e_src_col} + 14'd1) >= {1'b0, cfg.source_width};
  assign row_adv = active && (e_next_row < cfg.output_height) && row_hit;

  // quotient and remainder stepping
  assign col_sum      = {1'b0, e_col_rem} + {1'b0, step.col_rem};
  assign col_carry    = col_sum >= {1'b0, cfg.output_width};
  assign col_rem_step = col_carry ? DW'(col_sum - {1'b0, cfg.output_width}) : col_sum[DW-1:0];
  assign tgt_col_step = e_tgt_col + {1'b0, step.col_quo} + TW'(col_carry);

  assign row_sum      = {1'b0, e_row_rem} + {1'b0, step.row_rem};
  assign row_carry    = row_sum >= {1'b0, cfg.output_height};
  assign row_rem_step = row_carry ? DW'(row_sum - {1'b0, cfg.output_height}) : row_sum[DW-1:0];
  assign tgt_row_step = e_tgt_row + {1'b0, step.row_quo} + TW'(row_carry);

  always_comb begin
    src_col_next  = e_src_col;
    src_row_next  = e_src_row;
    next_col_next = e_next_col;
    next_row_next = e_next_row;
    col_rem_next  = e_col_rem;
    row_rem_next  = e_row_rem;
    tgt_col_next  = e_tgt_col;
    tgt_row_next  = e_tgt_row;
    if (emit) begin
      next_col_next = e_next_col + 1'b1;
      tgt_col_next  = tgt_col_step;
      col_rem_next  = col_rem_step;
    end
    if (row_end) begin
      if (row_adv) begin
        next_row_next = e_next_row + 1'b1;
        tgt_row_next  = tgt_row_step;
        row_rem_next  = row_rem_step;
        next_col_next = '0;
        tgt_col_next  = {2'b00, cfg.region_left};
        col_rem_next  = '0;
      end
      src_col_next = '0;
      if (e_src_row < cfg.source_height) begin
        src_row_next = e_src_row + 1'b1;
      end
    end else begin
      src_col_next = e_src_col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col  <= '0;
      src_row  <= '0;
      next_col <= '0;
      next_row <= '0;
      col_rem  <= '0;
      row_rem  <= '0;
      tgt_col  <= '0;
      tgt_row  <= '0;
      frame_ok <= 1'b0;
    end else if (accept) begin
      src_col  <= src_col_next;
      src_row  <= src_row_next;
      next_col <= next_col_next;
      next_row <= next_row_next;
      col_rem  <= col_rem_next;
      row_rem  <= row_rem_next;
      tgt_col  <= tgt_col_next;
      tgt_row  <= tgt_row_next;
      frame_ok <= e_frame_ok;
    end
  end

  assign push            = accept && emit;
  assign push_entry.gray = in_data.gray_in;
  assign push_entry.col  = e_next_col;
  assign push_entry.row  = e_next_row;

endmodule

@@ rtl/rcnd_queue.sv @@
// small fifo between front and back
module rcnd_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rcnd_pkg::q_entry_t push_entry,
  output logic               space,
  input  logic               pop,
  output logic               head_valid,
  output rcnd_pkg::q_entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rcnd_pkg::q_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign space      = count != CW'(DEPTH);
  assign head_valid = count != '0;
  assign do_pop     = pop && head_valid;
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/rcnd_back.sv @@
// back end: formats the selected pixel into the output register
module rcnd_back (
  input  logic               clk,
  input  logic               rst,
  input  rcnd_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  rcnd_pkg::q_entry_t head_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rcnd_pkg::out_t     out_data
);

  logic last;

  assign pop  = head_valid && (!out_valid || out_ready);
  assign last = (({1'b0, head_entry.col} + 14'd1) == {1'b0, cfg.output_width}) &&
                (({1'b0, head_entry.row} + 14'd1) == {1'b0, cfg.output_height});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.gray_out   <= head_entry.gray;
      out_data.out_column <= head_entry.col[rcnd_pkg::POS_W-1:0];
      out_data.out_row    <= head_entry.row[rcnd_pkg::POS_W-1:0];
      out_data.frame_last <= last;
    end
  end

endmodule

@@ rtl/roi_crop_nearest_downscaler_unit.sv @@
// top level of the roi crop and nearest-neighbor downscaler
//
// usage
// - in channel (in_valid/in_ready/in_data) takes one gray source pixel per request in
//   raster order; frame_begin on the first pixel restarts all counters
// - out channel (out_valid/out_ready/out_data) gives each selected pixel with its output
//   column and row; frame_last marks the pixel at the last output column and row
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one register per request;
//   cfg_ready is always high
// - throughput: one pixel per clock while in_ready is high, set by the combinational
//   counter and step update in the front end
// - a selected pixel passes the queue and the output register to reach the out channel
// - every configuration write, and reset itself, starts a recompute of the column and
//   row step quotients in two bit-serial dividers; in_ready is low meanwhile
// - reset clears counters, queue and output register and loads the default region;
//   nothing is output before the first frame_begin
// - when the receiver stalls, results pile up in the queue and in_ready drops only
//   once the queue is full
module roi_crop_nearest_downscaler_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rcnd_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rcnd_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcnd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rcnd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rcnd_pkg::cfg_t     cfg;
  rcnd_pkg::step_t    step;
  rcnd_pkg::q_entry_t push_entry, head_entry;

  logic cfg_write;
  logic recalc;       // high in the cycle after a write or reset: start dividers
  logic col_busy, row_busy;
  logic cfg_ok, cfg_ok_next;
  logic hold;
  logic q_space, push, pop, head_valid;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= 13'd640;
      cfg.source_height <= 13'd480;
      cfg.region_left   <= 12'd80;
      cfg.region_top    <= 12'd60;
      cfg.region_width  <= 13'd480;
      cfg.region_height <= 13'd360;
      cfg.output_width  <= 13'd320;
      cfg.output_height <= 13'd240;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rcnd_pkg::REG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data;
        rcnd_pkg::REG_SOURCE_HEIGHT: cfg.source_height <= cfg_data;
        rcnd_pkg::REG_REGION_LEFT:   cfg.region_left   <= cfg_data[rcnd_pkg::POS_W-1:0];
        rcnd_pkg::REG_REGION_TOP:    cfg.region_top    <= cfg_data[rcnd_pkg::POS_W-1:0];
        rcnd_pkg::REG_REGION_WIDTH:  cfg.region_width  <= cfg_data;
        rcnd_pkg::REG_REGION_HEIGHT: cfg.region_height <= cfg_data;
        rcnd_pkg::REG_OUTPUT_WIDTH:  cfg.output_width  <= cfg_data;
        rcnd_pkg::REG_OUTPUT_HEIGHT: cfg.output_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // region validity, registered; settles long before the dividers finish
  always_comb begin
    cfg_ok_next =
      (cfg.source_width != '0) && ({4'b0, cfg.source_width} <= rcnd_pkg::MAX_DIMENSION) &&
      (cfg.source_height != '0) && ({4'b0, cfg.source_height} <= rcnd_pkg::MAX_DIMENSION) &&
      (cfg.region_width != '0) && (cfg.region_height != '0) &&
      (cfg.output_width != '0) && (cfg.output_height != '0) &&
      (({2'b0, cfg.region_left} + {1'b0, cfg.region_width}) <= {1'b0, cfg.source_width}) &&
      (({2'b0, cfg.region_top} + {1'b0, cfg.region_height}) <= {1'b0, cfg.source_height}) &&
      (cfg.output_width <= cfg.region_width) &&
      (cfg.output_height <= cfg.region_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recalc <= 1'b1;
      cfg_ok <= 1'b0;
    end else begin
      recalc <= cfg_write;
      cfg_ok <= cfg_ok_next;
    end
  end

  // step quotients: region size over output size
  rcnd_div u_col_div (
    .clk       (clk),
    .rst       (rst),
    .start     (recalc),
    .dividend  (cfg.region_width),
    .divisor   (cfg.output_width),
    .busy      (col_busy),
    .quotient  (step.col_quo),
    .remainder (step.col_rem)
  );

  rcnd_div u_row_div (
    .clk       (clk),
    .rst       (rst),
    .start     (recalc),
    .dividend  (cfg.region_height),
    .divisor   (cfg.output_height),
    .busy      (row_busy),
    .quotient  (step.row_quo),
    .remainder (step.row_rem)
  );

  assign hold = recalc || col_busy || row_busy || cfg_write;

  rcnd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg),
    .step       (step),
    .cfg_ok     (cfg_ok),
    .hold       (hold),
    .q_ready    (q_space),
    .push       (push),
    .push_entry (push_entry)
  );

  rcnd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .space      (q_space),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rcnd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // no pixel taken while step quotients are being recomputed
  a_no_accept_in_recalc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(col_busy || row_busy || recalc))
    else $error("pixel request taken during step recompute");

  // a register write blocks pixels on the following cycle
  a_write_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !in_ready)
    else $error("in_ready high right after a configuration write");

  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    col_busy == row_busy)
    else $error("column and row dividers out of step");

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

@@ tb/tb_roi_crop_nearest_downscaler_unit.sv @@
// testbench of the roi crop and nearest-neighbor downscaler, self-checking against a predictor
`timescale 1ns / 1ps

module tb_roi_crop_nearest_downscaler_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 1460;
  // a selected pixel passes the queue and the output register after its request, keep some margin
  localparam int SETTLE_CYCLES  = 4;

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  rcnd_pkg::in_t                    in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  rcnd_pkg::out_t                   out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rcnd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rcnd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  roi_crop_nearest_downscaler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the register file and of the stream position
  // ---------------------------------------------------------------------------
  rcnd_pkg::cfg_t region_cfg;
  int unsigned col_pos, row_pos;            // position of the current source pixel
  int unsigned out_col_next, out_row_next;  // next output pixel to emit
  int unsigned col_target, row_target;      // source position of that output pixel
  int unsigned col_rem, row_rem;            // remainders of the quotient stepping
  bit          frame_ok;                    // region judged valid at frame start

  rcnd_pkg::out_t expected_pixels[$];

  // bookkeeping
  int  errors          = 0;
  int  pixels_sent     = 0;
  int  pixels_in_frame = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  random_frames   = 0;
  bit  tx_gaps         = 1'b1;
  bit  rx_stalls       = 1'b1;
  int  stall_left      = 0;
  int  idle_cycles     = 0;

  // reset defaults of the register file
  function automatic rcnd_pkg::cfg_t default_cfg();
    rcnd_pkg::cfg_t c;
    c.source_width  = 13'd640;
    c.source_height = 13'd480;
    c.region_left   = 12'd80;
    c.region_top    = 12'd60;
    c.region_width  = 13'd480;
    c.region_height = 13'd360;
    c.output_width  = 13'd320;
    c.output_height = 13'd240;
    return c;
  endfunction

  // region and output sizes legal for the current register values
  function automatic bit region_valid();
    int unsigned sw, sh, rl, rt, rw, rh, ow, oh;
    sw = 32'(region_cfg.source_width);
    sh = 32'(region_cfg.source_height);
    rl = 32'(region_cfg.region_left);
    rt = 32'(region_cfg.region_top);
    rw = 32'(region_cfg.region_width);
    rh = 32'(region_cfg.region_height);
    ow = 32'(region_cfg.output_width);
    oh = 32'(region_cfg.output_height);
    if (sw < 1 || sw > rcnd_pkg::MAX_DIMENSION) return 1'b0;
    if (sh < 1 || sh > rcnd_pkg::MAX_DIMENSION) return 1'b0;
    if (rw < 1 || rh < 1) return 1'b0;
    if (ow < 1 || oh < 1) return 1'b0;
    if (rl + rw > sw) return 1'b0;
    if (rt + rh > sh) return 1'b0;
    if (ow > rw || oh > rh) return 1'b0;
    return 1'b1;
  endfunction

  // one quotient/remainder step, returns {new target, new remainder}
  function automatic logic [63:0] next_target(input int unsigned tgt, input int unsigned rem,
                                              input int unsigned span, input int unsigned div);
    int unsigned t, r;
    t = tgt + span / div;
    r = rem + span % div;
    if (r >= div) begin
      r = r - div;
      t = t + 1;
    end
    return {t, r};
  endfunction

  // register write as the block sees it
  function automatic void apply_reg(input logic [rcnd_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [rcnd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      rcnd_pkg::REG_SOURCE_WIDTH:  region_cfg.source_width  = val;
      rcnd_pkg::REG_SOURCE_HEIGHT: region_cfg.source_height = val;
      rcnd_pkg::REG_REGION_LEFT:   region_cfg.region_left   = val[rcnd_pkg::POS_W-1:0];
      rcnd_pkg::REG_REGION_TOP:    region_cfg.region_top    = val[rcnd_pkg::POS_W-1:0];
      rcnd_pkg::REG_REGION_WIDTH:  region_cfg.region_width  = val;
      rcnd_pkg::REG_REGION_HEIGHT: region_cfg.region_height = val;
      rcnd_pkg::REG_OUTPUT_WIDTH:  region_cfg.output_width  = val;
      rcnd_pkg::REG_OUTPUT_HEIGHT: region_cfg.output_height = val;
      default: ;
    endcase
  endfunction

  // advance the stream by one source pixel, queue the output pixel it selects
  function automatic void crop_step(input rcnd_pkg::in_t px);
    int unsigned    sw, sh, rw, rh, ow, oh;
    bit             ok;
    logic [63:0]    nx;
    rcnd_pkg::out_t res;
    sw = 32'(region_cfg.source_width);
    sh = 32'(region_cfg.source_height);
    rw = 32'(region_cfg.region_width);
    rh = 32'(region_cfg.region_height);
    ow = 32'(region_cfg.output_width);
    oh = 32'(region_cfg.output_height);

    // frame start restarts every counter and judges the region
    if (px.frame_begin) begin
      col_pos      = 0;
      row_pos      = 0;
      out_col_next = 0;
      out_row_next = 0;
      col_target   = 32'(region_cfg.region_left);
      row_target   = 32'(region_cfg.region_top);
      col_rem      = 0;
      row_rem      = 0;
      frame_ok     = region_valid();
    end

    // registers are rechecked on every pixel as well
    ok = frame_ok && region_valid();

    if (ok && out_row_next < oh && out_col_next < ow &&
        row_pos == row_target && col_pos == col_target) begin
      res.gray_out   = px.gray_in;
      res.out_column = out_col_next[rcnd_pkg::POS_W-1:0];
      res.out_row    = out_row_next[rcnd_pkg::POS_W-1:0];
      res.frame_last = (out_col_next + 1 == ow) && (out_row_next + 1 == oh);
      expected_pixels.insert(expected_pixels.size(), res);
      out_col_next = out_col_next + 1;
      nx         = next_target(col_target, col_rem, rw, ow);
      col_target = nx[63:32];
      col_rem    = nx[31:0];
    end

    // end of a source row: step the row target, column counter wraps
    if (col_pos + 1 >= sw) begin
      if (ok && out_row_next < oh && row_pos == row_target) begin
        out_row_next = out_row_next + 1;
        nx           = next_target(row_target, row_rem, rh, oh);
        row_target   = nx[63:32];
        row_rem      = nx[31:0];
        out_col_next = 0;
        col_target   = 32'(region_cfg.region_left);
        col_rem      = 0;
      end
      col_pos = 0;
      if (row_pos < sh) row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // request drivers
  // ---------------------------------------------------------------------------

  // one pixel request, held until accepted, then an optional gap
  task automatic send_pixel(input logic [7:0] gray, input logic first);
    rcnd_pkg::in_t px;
    int            gap;
    px.gray_in     = gray;
    px.frame_begin = first;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    crop_step(px);
    pixels_sent++;
    if (frame_ok) pixels_in_frame++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every queued output pixel has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    // a last pixel with no output may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller is to call this only while the block is idle, the task does not enforce it
  task automatic write_reg(input logic [rcnd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rcnd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [rcnd_pkg::CFG_DATA_W-1:0] cfg_field(
      input rcnd_pkg::cfg_t c, input logic [rcnd_pkg::CFG_INDEX_W-1:0] idx);
    case (idx)
      rcnd_pkg::REG_SOURCE_WIDTH:  return c.source_width;
      rcnd_pkg::REG_SOURCE_HEIGHT: return c.source_height;
      rcnd_pkg::REG_REGION_LEFT:   return {1'b0, c.region_left};
      rcnd_pkg::REG_REGION_TOP:    return {1'b0, c.region_top};
      rcnd_pkg::REG_REGION_WIDTH:  return c.region_width;
      rcnd_pkg::REG_REGION_HEIGHT: return c.region_height;
      rcnd_pkg::REG_OUTPUT_WIDTH:  return c.output_width;
      default:                     return c.output_height;
    endcase
  endfunction

  // drain, then write the whole register file in shuffled order
  task automatic write_all(input rcnd_pkg::cfg_t c);
    logic [rcnd_pkg::CFG_INDEX_W-1:0] order [8];
    logic [rcnd_pkg::CFG_INDEX_W-1:0] tmp;
    int                               j;
    wait_drained();
    order[0] = rcnd_pkg::REG_SOURCE_WIDTH;
    order[1] = rcnd_pkg::REG_SOURCE_HEIGHT;
    order[2] = rcnd_pkg::REG_REGION_LEFT;
    order[3] = rcnd_pkg::REG_REGION_TOP;
    order[4] = rcnd_pkg::REG_REGION_WIDTH;
    order[5] = rcnd_pkg::REG_REGION_HEIGHT;
    order[6] = rcnd_pkg::REG_OUTPUT_WIDTH;
    order[7] = rcnd_pkg::REG_OUTPUT_HEIGHT;
    for (int k = 7; k > 0; k--) begin
      j        = $urandom_range(k, 0);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < 8; k++) write_reg(order[k], cfg_field(c, order[k]));
  endtask

  task automatic load_config(input int sw, input int sh, input int rl, input int rt,
                             input int rw, input int rh, input int ow, input int oh);
    rcnd_pkg::cfg_t c;
    c.source_width  = rcnd_pkg::DIM_W'(sw);
    c.source_height = rcnd_pkg::DIM_W'(sh);
    c.region_left   = rcnd_pkg::POS_W'(rl);
    c.region_top    = rcnd_pkg::POS_W'(rt);
    c.region_width  = rcnd_pkg::DIM_W'(rw);
    c.region_height = rcnd_pkg::DIM_W'(rh);
    c.output_width  = rcnd_pkg::DIM_W'(ow);
    c.output_height = rcnd_pkg::DIM_W'(oh);
    write_all(c);
  endtask

  // ---------------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------------
  rcnd_pkg::out_t want;
  int             roll;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      // compare each accepted output pixel against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("output pixel with none expected: col %0d row %0d gray %0d",
                 out_data.out_column, out_data.out_row, out_data.gray_out);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (out_data.gray_out !== want.gray_out) begin
            $error("gray_out: expected %0d, actual %0d", want.gray_out, out_data.gray_out);
            errors++;
          end
          if (out_data.out_column !== want.out_column) begin
            $error("out_column: expected %0d, actual %0d", want.out_column, out_data.out_column);
            errors++;
          end
          if (out_data.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, out_data.out_row);
            errors++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, out_data.frame_last);
            errors++;
          end
        end
      end
      // receiver stalls: mostly short, a few long
      if (!rx_stalls) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left = (roll < 95) ? $urandom_range(2, 0) : $urandom_range(40, 10);
        end
      end
    end
  end

  // watchdog: too long with no request moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing may come out before the first frame start, and the default
  // region does not reach the first pixels of a frame
  task automatic test_idle_before_frame();
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h5A, 1'b1);
    send_pixel(8'hA5, 1'b0);
    wait_drained();
  endtask

  // largest legal sizes, one-to-one, and a region in the far corner
  task automatic test_size_limits();
    load_config(4096, 4096, 0, 0, 4096, 4096, 4096, 4096);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    load_config(4096, 4096, 4095, 4095, 1, 1, 1, 1);
    send_pixel(8'h3C, 1'b1);
    wait_drained();
  endtask

  // a 1x1 output from a 2x2 frame, then one register at a time made illegal
  task automatic test_invalid_regions();
    logic [rcnd_pkg::CFG_INDEX_W-1:0] bad_idx [10];
    logic [rcnd_pkg::CFG_DATA_W-1:0]  bad_val [10];
    logic [rcnd_pkg::CFG_DATA_W-1:0]  good_val;
    bad_idx[0] = rcnd_pkg::REG_SOURCE_WIDTH;  bad_val[0] = 13'd0;
    bad_idx[1] = rcnd_pkg::REG_SOURCE_WIDTH;  bad_val[1] = 13'h1FFF;   // above max dimension
    bad_idx[2] = rcnd_pkg::REG_SOURCE_HEIGHT; bad_val[2] = 13'd4097;
    bad_idx[3] = rcnd_pkg::REG_REGION_WIDTH;  bad_val[3] = 13'd0;
    bad_idx[4] = rcnd_pkg::REG_REGION_HEIGHT; bad_val[4] = 13'd0;
    bad_idx[5] = rcnd_pkg::REG_OUTPUT_WIDTH;  bad_val[5] = 13'd0;
    bad_idx[6] = rcnd_pkg::REG_OUTPUT_HEIGHT; bad_val[6] = 13'd3;      // upscaling rows
    bad_idx[7] = rcnd_pkg::REG_REGION_LEFT;   bad_val[7] = 13'h1FFF;   // region past right edge
    bad_idx[8] = rcnd_pkg::REG_REGION_TOP;    bad_val[8] = 13'd1;      // region past bottom edge
    bad_idx[9] = rcnd_pkg::REG_OUTPUT_WIDTH;  bad_val[9] = 13'd3;      // upscaling columns
    load_config(2, 2, 0, 0, 2, 2, 1, 1);
    send_pixel(8'h81, 1'b1);
    for (int k = 0; k < 10; k++) begin
      wait_drained();
      good_val = cfg_field(region_cfg, bad_idx[k]);
      write_reg(bad_idx[k], bad_val[k]);
      send_pixel(8'($urandom_range(255, 0)), 1'b1);
      wait_drained();
      write_reg(bad_idx[k], good_val);
    end
    // legal again: output resumes
    send_pixel(8'h7E, 1'b1);
    wait_drained();
  endtask

  // single-pixel frame with pixels past its end, a restart inside a frame,
  // and a register change that stays legal in the middle of a frame
  task automatic test_short_frames();
    load_config(1, 1, 0, 0, 1, 1, 1, 1);
    send_pixel(8'hC3, 1'b1);
    send_pixel(8'h11, 1'b0);
    send_pixel(8'h22, 1'b0);
    load_config(3, 2, 0, 0, 3, 2, 3, 2);
    send_pixel(8'h01, 1'b1);
    send_pixel(8'h02, 1'b0);
    send_pixel(8'h03, 1'b1);
    send_pixel(8'h04, 1'b0);
    // sender holds off until the block has drained
    wait_drained();
    write_reg(rcnd_pkg::REG_OUTPUT_WIDTH, 13'd2);
    for (int k = 0; k < 4; k++) send_pixel(8'($urandom_range(255, 0)), 1'b0);
    wait_drained();
  endtask

  // random frames of small size, mostly well formed, some broken or restarted
  task automatic test_random_frames();
    rcnd_pkg::cfg_t                   c;
    int                               sw, sh, rw, rh, npix, event_at, start, roll_cfg;
    logic [rcnd_pkg::CFG_INDEX_W-1:0] idx;
    logic [rcnd_pkg::CFG_DATA_W-1:0]  val;
    bit                               big;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      random_frames++;
      roll_cfg = $urandom_range(99, 0);
      big      = (roll_cfg < 10);
      sw = big ? $urandom_range(40, 16) : $urandom_range(24, 1);
      sh = big ? $urandom_range(12, 4)  : $urandom_range(12, 1);
      rw = $urandom_range(sw, 1);
      rh = $urandom_range(sh, 1);
      c.source_width  = rcnd_pkg::DIM_W'(sw);
      c.source_height = rcnd_pkg::DIM_W'(sh);
      c.region_width  = rcnd_pkg::DIM_W'(rw);
      c.region_height = rcnd_pkg::DIM_W'(rh);
      c.region_left   = rcnd_pkg::POS_W'($urandom_range(sw - rw, 0));
      c.region_top    = rcnd_pkg::POS_W'($urandom_range(sh - rh, 0));
      roll_cfg = $urandom_range(99, 0);
      if (roll_cfg < 20) begin
        c.output_width  = rcnd_pkg::DIM_W'(rw);
        c.output_height = rcnd_pkg::DIM_W'(rh);
      end else if (roll_cfg < 30) begin
        c.output_width  = 13'd1;
        c.output_height = 13'd1;
      end else begin
        c.output_width  = rcnd_pkg::DIM_W'($urandom_range(rw, 1));
        c.output_height = rcnd_pkg::DIM_W'($urandom_range(rh, 1));
      end
      write_all(c);

      // some frames get one register spoiled with a raw value
      if ($urandom_range(99, 0) < 15) begin
        idx = rcnd_pkg::CFG_INDEX_W'($urandom_range(7, 0));
        case ($urandom_range(3, 0))
          0:       val = 13'd0;
          1:       val = 13'h1FFF;
          2:       val = 13'd4097;
          default: val = rcnd_pkg::CFG_DATA_W'($urandom_range(8191, 0));
        endcase
        write_reg(idx, val);
      end

      // a quarter of the frames run with no idling on either side
      roll_cfg  = $urandom_range(99, 0);
      tx_gaps   = (roll_cfg >= 25);
      rx_stalls = (roll_cfg >= 25);

      roll_cfg = $urandom_range(99, 0);
      if (roll_cfg < 80)      npix = sw * sh;
      else if (roll_cfg < 90) npix = $urandom_range(sw * sh, 1);
      else                    npix = sw * sh + $urandom_range(2 * sw, 1);

      event_at = ($urandom_range(99, 0) < 15 && npix > 1) ? $urandom_range(npix - 1, 1) : -1;

      for (int k = 0; k < npix; k++) begin
        if (k == event_at) begin
          // pause until drained, sometimes change one register mid-frame
          wait_drained();
          if ($urandom_range(1, 0) == 1) begin
            idx = rcnd_pkg::CFG_INDEX_W'($urandom_range(7, 0));
            write_reg(idx, rcnd_pkg::CFG_DATA_W'($urandom_range(24, 0)));
          end
        end
        send_pixel(8'($urandom_range(255, 0)), (k == 0) || ($urandom_range(99, 0) == 0));
      end
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    region_cfg   = default_cfg();
    col_pos      = 0;
    row_pos      = 0;
    out_col_next = 0;
    out_row_next = 0;
    col_target   = 0;
    row_target   = 0;
    col_rem      = 0;
    row_rem      = 0;
    frame_ok     = 1'b0;

    // synchronous reset
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_before_frame();
    test_size_limits();
    test_invalid_regions();
    test_short_frames();
    test_random_frames();

    // final drain and settle
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d output pixels never arrived", expected_pixels.size());
      errors++;
    end

    $display("run: %0d pixel requests (%0d in legal frames), %0d output pixels checked",
             pixels_sent, pixels_in_frame, results_checked);
    $display("%0d register writes; size limits, illegal regions, restarts, %0d random frames",
             reg_writes, random_frames);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
